// ===== sv/fpaf_pkg.sv =====
package fpaf_pkg;

  localparam int AmountWidth       = 64;
  localparam int FracDigitsDefault = 6;
  localparam int AmountBitsDefault = 64;

  localparam int CfgAddrWidth = 3;
  localparam int CfgDataWidth = 32;

  localparam logic [0:0] RegBufferLimit   = 1'b0;
  localparam logic [7:0] BufferLimitReset = 8'd32;

  localparam logic [7:0] CharNul   = 8'h00;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharComma = 8'h2c;
  localparam logic [7:0] CharPoint = 8'h2e;

endpackage

// ===== sv/fixed_point_amount_formatter.sv =====
// Fixed-point amount formatter.
// An amount in units of 10^-FRACTION_DIGITS enters on the in_ stream
// (in_tdata, low AMOUNT_BITS bits used) and leaves as display text on the
// out_ stream, one ASCII character per transfer: whole part with a comma
// every three digits, then '.' and the fraction without trailing zeros.
// The text ends with a NUL transfer that carries out_tlast. If the text and
// its NUL would exceed buffer_limit, a single transfer with out_tdata zero,
// out_tuser and out_tlast high is sent instead.
// Steps: bit-serial binary to BCD conversion, a pass over the BCD digits
// (20 at 64 bits) to measure the text, a check of the length, then one
// character per cycle while the receiver takes them, where a skipped
// leading zero sends nothing. One amount is in work at a time; in_tready
// is high only while the block is idle, so a new amount is not taken
// before the last one's terminator has been emitted.
// The output register lets the next amount be taken while the terminator
// still waits. When the receiver stalls, character output holds and the
// block waits. Reset empties the output, drops any amount in work and sets
// buffer_limit (cfg address 0) to 32.
module fixed_point_amount_formatter
  import fpaf_pkg::*;
#(
  parameter int FRACTION_DIGITS = FracDigitsDefault,
  parameter int AMOUNT_BITS     = AmountBitsDefault
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [AmountWidth-1:0]  in_tdata,    // amount
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [7:0]              out_tdata,   // out_char
  output logic                    out_tuser,   // overflow
  output logic                    out_tlast,
  input  logic                    cfg_psel,
  input  logic                    cfg_penable,
  input  logic                    cfg_pwrite,
  input  logic [CfgAddrWidth-1:0] cfg_paddr,
  input  logic [CfgDataWidth-1:0] cfg_pwdata,
  output logic [CfgDataWidth-1:0] cfg_prdata,
  output logic                    cfg_pready
);

  localparam int DigitsForBits = (AMOUNT_BITS * 30103) / 100000 + 1;
  localparam int NumDigits     = (DigitsForBits > FRACTION_DIGITS) ? DigitsForBits
                                                                   : FRACTION_DIGITS + 1;
  localparam int BcdW    = NumDigits * 4;
  localparam int IdxW    = $clog2(NumDigits);
  localparam int KeepW   = $clog2(FRACTION_DIGITS + 1);
  localparam int BitW    = $clog2(AMOUNT_BITS);
  localparam int WholeD  = NumDigits - FRACTION_DIGITS;
  localparam int LenMax  = WholeD + (WholeD - 1) / 3 + FRACTION_DIGITS + 2;
  localparam int LenW    = $clog2(LenMax + 1);
  localparam int CmpW    = ((LenW > 8) ? LenW : 8) + 1;
  localparam logic [1:0] PmodInit = 2'((NumDigits - 1 - FRACTION_DIGITS) % 3);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_CONV   = 10'b0000000010,
    S_SCAN   = 10'b0000000100,
    S_DECIDE = 10'b0000001000,
    S_WHOLE  = 10'b0000010000,
    S_COMMA  = 10'b0000100000,
    S_POINT  = 10'b0001000000,
    S_FRAC   = 10'b0010000000,
    S_TERM   = 10'b0100000000,
    S_OVF    = 10'b1000000000
  } state_t;

  state_t                 state_r, state_nxt;
  logic [AMOUNT_BITS-1:0] amt_r, amt_nxt;
  logic [BcdW-1:0]        bcd_r, bcd_nxt;
  logic [BcdW-1:0]        bcd_adj, bcd_rot;
  logic [BitW-1:0]        bitcnt_r, bitcnt_nxt;
  logic [IdxW-1:0]        idx_r, idx_nxt;
  logic [1:0]             pmod_r, pmod_nxt, pmod_dec;
  logic                   started_r, started_nxt;
  logic [LenW-1:0]        len_r, len_nxt, total;
  logic [KeepW-1:0]       keep_r, keep_nxt;
  logic [7:0]             limit_r;
  logic                   out_tvalid_r;
  logic [7:0]             out_tdata_r;
  logic                   out_tuser_r, out_tlast_r;

  logic       slot_free, emit, emit_user, emit_last;
  logic [7:0] emit_char;
  logic [3:0] top_dig;
  logic       dig_nz, in_whole, at_units, take_dig, comma_after;
  logic       cfg_write;
  logic       overflow;

  assign slot_free   = !out_tvalid_r || out_tready;
  assign top_dig     = bcd_r[BcdW-1 -: 4];
  assign dig_nz      = top_dig != 4'd0;
  assign in_whole    = idx_r >= IdxW'(FRACTION_DIGITS);
  assign at_units    = idx_r == IdxW'(FRACTION_DIGITS);
  assign take_dig    = started_r || dig_nz || at_units;
  assign comma_after = !at_units && (pmod_r == 2'd0);
  assign pmod_dec    = (pmod_r == 2'd0) ? 2'd2 : pmod_r - 2'd1;
  assign bcd_rot     = {bcd_r[BcdW-5:0], top_dig};

  // add three to every digit of five or more before the shift
  always_comb begin
    for (int d = 0; d < NumDigits; d++) begin
      bcd_adj[d*4 +: 4] = (bcd_r[d*4 +: 4] >= 4'd5) ? bcd_r[d*4 +: 4] + 4'd3
                                                   : bcd_r[d*4 +: 4];
    end
  end

  assign total    = len_r + ((keep_r != '0) ? LenW'(keep_r) + LenW'(1) : LenW'(0));
  assign overflow = (CmpW'(total) + CmpW'(1)) > CmpW'(limit_r);

  always_comb begin
    state_nxt   = state_r;
    amt_nxt     = amt_r;
    bcd_nxt     = bcd_r;
    bitcnt_nxt  = bitcnt_r;
    idx_nxt     = idx_r;
    pmod_nxt    = pmod_r;
    started_nxt = started_r;
    len_nxt     = len_r;
    keep_nxt    = keep_r;
    emit        = 1'b0;
    emit_char   = CharNul;
    emit_user   = 1'b0;
    emit_last   = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          amt_nxt    = in_tdata[AMOUNT_BITS-1:0];
          bcd_nxt    = '0;
          bitcnt_nxt = BitW'(AMOUNT_BITS - 1);
          state_nxt  = S_CONV;
        end
      end
      S_CONV: begin
        bcd_nxt = {bcd_adj[BcdW-2:0], amt_r[AMOUNT_BITS-1]};
        amt_nxt = {amt_r[AMOUNT_BITS-2:0], 1'b0};
        if (bitcnt_r == '0) begin
          idx_nxt     = IdxW'(NumDigits - 1);
          pmod_nxt    = PmodInit;
          started_nxt = 1'b0;
          len_nxt     = '0;
          keep_nxt    = '0;
          state_nxt   = S_SCAN;
        end else begin
          bitcnt_nxt = bitcnt_r - BitW'(1);
        end
      end
      S_SCAN: begin
        if (in_whole) begin
          pmod_nxt = pmod_dec;
          if (take_dig) begin
            started_nxt = 1'b1;
            len_nxt     = len_r + LenW'(1) + LenW'(comma_after);
          end
        end else if (dig_nz) begin
          keep_nxt = KeepW'(IdxW'(FRACTION_DIGITS) - idx_r);
        end
        bcd_nxt = bcd_rot;
        if (idx_r == '0) begin
          state_nxt = S_DECIDE;
        end else begin
          idx_nxt = idx_r - IdxW'(1);
        end
      end
      S_DECIDE: begin
        idx_nxt     = IdxW'(NumDigits - 1);
        pmod_nxt    = PmodInit;
        started_nxt = 1'b0;
        state_nxt   = overflow ? S_OVF : S_WHOLE;
      end
      S_WHOLE: begin
        if (!take_dig) begin
          bcd_nxt  = bcd_rot;
          idx_nxt  = idx_r - IdxW'(1);
          pmod_nxt = pmod_dec;
        end else if (slot_free) begin
          emit        = 1'b1;
          emit_char   = CharZero + {4'd0, top_dig};
          bcd_nxt     = bcd_rot;
          idx_nxt     = idx_r - IdxW'(1);
          pmod_nxt    = pmod_dec;
          started_nxt = 1'b1;
          if (at_units) begin
            state_nxt = (keep_r != '0) ? S_POINT : S_TERM;
          end else if (comma_after) begin
            state_nxt = S_COMMA;
          end
        end
      end
      S_COMMA: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_char = CharComma;
          state_nxt = S_WHOLE;
        end
      end
      S_POINT: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_char = CharPoint;
          state_nxt = S_FRAC;
        end
      end
      S_FRAC: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_char = CharZero + {4'd0, top_dig};
          bcd_nxt   = bcd_rot;
          idx_nxt   = idx_r - IdxW'(1);
          if (keep_r == KeepW'(1)) begin
            state_nxt = S_TERM;
          end else begin
            keep_nxt = keep_r - KeepW'(1);
          end
        end
      end
      S_TERM: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_last = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_OVF: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_user = 1'b1;
          emit_last = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign cfg_write = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
      limit_r      <= BufferLimitReset;
    end else begin
      state_r <= state_nxt;
      if (emit) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      if (cfg_write && (cfg_paddr[2] == RegBufferLimit)) begin
        limit_r <= cfg_pwdata[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    amt_r     <= amt_nxt;
    bcd_r     <= bcd_nxt;
    bitcnt_r  <= bitcnt_nxt;
    idx_r     <= idx_nxt;
    pmod_r    <= pmod_nxt;
    started_r <= started_nxt;
    len_r     <= len_nxt;
    keep_r    <= keep_nxt;
    if (emit) begin
      out_tdata_r <= emit_char;
      out_tuser_r <= emit_user;
      out_tlast_r <= emit_last;
    end
  end

  assign in_tready  = state_r == S_IDLE;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tlast  = out_tlast_r;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == RegBufferLimit) ? {24'd0, limit_r} : '0;

  // an accepted amount always starts the conversion
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r == S_CONV)
    else $error("amount transfer did not start conversion");

  // an overflow result is a lone zero character that ends the run
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast && (out_tdata == CharNul))
    else $error("overflow result malformed");

  // a pending character that is not the end keeps the sequencer emitting
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> (state_r == S_WHOLE || state_r == S_COMMA ||
                                  state_r == S_POINT || state_r == S_FRAC ||
                                  state_r == S_TERM))
    else $error("text run left without terminator");

endmodule
